// ===== hw/rtl/mtw_pkg.sv =====
// Shared types, constants and helper functions for the MT19937 word and index generator.
// Has no dependencies. Every module imports it; the interfaces do not.
package mtw_pkg;

  localparam int STATE_WORDS    = 624;
  localparam int ADDR_W         = 10;
  localparam int MAX_INDEX_BITS = 52;
  localparam int BITS_W         = 6;
  localparam int SHIFT_SPAN     = 397;

  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] LCG_MUL      = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;
  localparam logic [5:0]  SCRAMBLE_END = 6'd50;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] WRAP_POS  = ADDR_W'(STATE_WORDS);
  localparam logic [ADDR_W-1:0] SPAN_FWD  = ADDR_W'(SHIFT_SPAN);
  localparam logic [ADDR_W-1:0] SPAN_BACK = ADDR_W'(STATE_WORDS - SHIFT_SPAN);

  localparam logic [52:0] BOUND_LIMIT = 53'd1 << MAX_INDEX_BITS;

  // Request modes
  localparam logic [1:0] MODE_SEED  = 2'd0;
  localparam logic [1:0] MODE_WORD  = 2'd1;
  localparam logic [1:0] MODE_INDEX = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Access bundle from the sequencer to the state memory
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [31:0]       wd;
  } mtw_ram_req_t;

  function automatic logic [31:0] lcg_next(input logic [31:0] x);
    logic [31:0] p;
    p = x * LCG_MUL;
    return p + 32'd1;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hw/rtl/mtw_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Does not depend on mtw_pkg and does not import it.
interface mtw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] seed_value;
  logic [52:0] bound;
  modport source (output valid, mode, seed_value, bound, input ready);
  modport sink   (input valid, mode, seed_value, bound, output ready);
endinterface

interface mtw_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [51:0] index;
  logic        is_index;
  modport source (output valid, word, index, is_index, input ready);
  modport sink   (input valid, word, index, is_index, output ready);
endinterface

// ===== hw/rtl/mtw_state_ram.sv =====
// State word memory: 624 x 32, one write port, two registered read ports.
// Depends on mtw_pkg for the access bundle.
module mtw_state_ram
  import mtw_pkg::*;
(
  input  logic         clk,
  input  mtw_ram_req_t req,
  output logic [31:0]  rda,
  output logic [31:0]  rdb
);

  logic [31:0] mem [STATE_WORDS];
  logic [31:0] rda_r;
  logic [31:0] rdb_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rda_r <= mem[req.ra];
      rdb_r <= mem[req.rb];
    end
  end

  assign rda = rda_r;
  assign rdb = rdb_r;

endmodule

// ===== hw/rtl/mt19937_word_and_index_generator.sv =====
// MT19937 word and index generator top level with its sequencer.
// Depends on mtw_pkg, mtw_if and mtw_state_ram.
//
// Usage:
//   in_ch  : request item {mode, seed_value, bound}. Mode 0 seeds and gives no
//            result; mode 1 returns one tempered word; mode 2 returns one index
//            below bound (0 for bound 0); mode 3 is dropped.
//   out_ch : result item {word, index, is_index}, held in an output register.
//   Only one request is in work at a time; in_ch.ready is high while the
//   sequencer is idle, also while an earlier result still waits on out_ch.
//   A word draw passes through the prep, read and temper steps to the emit step.
//   Regeneration of all 624 words takes one read and one write slot of the state
//   memory per word. Seeding runs one LCG multiply per cycle, first scrambling
//   the seed and then filling all 624 words. An index draw first sizes the bound
//   one bit at a time, then reads one word per 16-bit chunk, repeated while the
//   masked value is rejected.
//   Reset clears the position to 624 and the seeded flag; the first draw seeds
//   with 4357. A stalled receiver holds the result; a finished request waits
//   in its last step until the output register frees up.
module mt19937_word_and_index_generator
  import mtw_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  mtw_req_if.sink   in_ch,
  mtw_rsp_if.source out_ch
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BITS   = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_SCR    = 4'd3;
  localparam logic [3:0] S_FILL   = 4'd4;
  localparam logic [3:0] S_RG_PRE = 4'd5;
  localparam logic [3:0] S_RG_LD  = 4'd6;
  localparam logic [3:0] S_RG_RD  = 4'd7;
  localparam logic [3:0] S_RG_WR  = 4'd8;
  localparam logic [3:0] S_RD     = 4'd9;
  localparam logic [3:0] S_TEMP   = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [52:0]       bound_r, bound_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic [2:0]        chunks_r, chunks_nxt;
  logic [2:0]        ccnt_r, ccnt_nxt;
  logic [51:0]       v_r, v_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              seeded_r, seeded_nxt;
  logic [31:0]       lcg_r, lcg_nxt;
  logic [31:0]       cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_word_r, out_word_nxt;
  logic [51:0]       out_index_r, out_index_nxt;
  logic              out_is_index_r, out_is_index_nxt;
  logic [31:0]       res_word_r, res_word_nxt;

  mtw_ram_req_t ram_req;
  logic [31:0]  rda, rdb;
  logic [31:0]  lcg_step;
  logic [31:0]  tw;
  logic [31:0]  ymix;
  logic [51:0]  v_shift;
  logic [51:0]  v_mask;
  logic [51:0]  mask;
  logic [ADDR_W-1:0] nxt_addr, far_addr;

  mtw_state_ram u_ram (
    .clk (clk),
    .req (ram_req),
    .rda (rda),
    .rdb (rdb)
  );

  assign lcg_step = lcg_next(lcg_r);
  assign tw       = temper(rda);
  assign ymix     = {cur_r[31], rda[30:0]};
  assign v_shift  = {v_r[35:0], tw[31:16]};
  assign mask     = 52'((53'd1 << bits_r) - 53'd1);
  assign v_mask   = v_shift & mask;
  assign nxt_addr = (cnt_r == LAST_ADDR) ? '0 : cnt_r + 1'b1;
  assign far_addr = (cnt_r < SPAN_BACK) ? cnt_r + SPAN_FWD : cnt_r - SPAN_BACK;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.word     = out_word_r;
  assign out_ch.index    = out_index_r;
  assign out_ch.is_index = out_is_index_r;

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    bound_nxt        = bound_r;
    bits_nxt         = bits_r;
    chunks_nxt       = chunks_r;
    ccnt_nxt         = ccnt_r;
    v_nxt            = v_r;
    cnt_nxt          = cnt_r;
    pos_nxt          = pos_r;
    seeded_nxt       = seeded_r;
    lcg_nxt          = lcg_r;
    cur_nxt          = cur_r;
    res_word_nxt     = res_word_r;
    out_valid_nxt    = out_valid_r;
    out_word_nxt     = out_word_r;
    out_index_nxt    = out_index_r;
    out_is_index_nxt = out_is_index_r;
    ram_req          = '0;

    // Drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt = in_ch.mode;
          case (in_ch.mode)
            MODE_SEED: begin
              lcg_nxt   = in_ch.seed_value;
              cnt_nxt   = '0;
              state_nxt = S_SCR;
            end
            MODE_WORD: begin
              state_nxt = S_PREP;
            end
            MODE_INDEX: begin
              bound_nxt = (in_ch.bound > BOUND_LIMIT) ? BOUND_LIMIT : in_ch.bound;
              bits_nxt  = '0;
              v_nxt     = '0;
              ccnt_nxt  = '0;
              state_nxt = (in_ch.bound == '0) ? S_EMIT : S_BITS;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_BITS: begin
        // Find the smallest b with 2^b >= bound, one step a cycle
        if ((53'd1 << bits_r) < bound_r) begin
          bits_nxt = bits_r + 1'b1;
        end else begin
          chunks_nxt = {1'b0, bits_r[5:4]} + 3'd1;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        if (!seeded_r) begin
          lcg_nxt   = DEFAULT_SEED;
          cnt_nxt   = '0;
          state_nxt = S_SCR;
        end else if (pos_r == WRAP_POS) begin
          state_nxt = S_RG_PRE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_SCR: begin
        // Scramble the seed: 50 steps plus one discarded value
        lcg_nxt = lcg_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[5:0] == SCRAMBLE_END) begin
          cnt_nxt   = '0;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        lcg_nxt    = lcg_step;
        ram_req.we = 1'b1;
        ram_req.wa = cnt_r;
        ram_req.wd = lcg_step;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == LAST_ADDR) begin
          pos_nxt    = WRAP_POS;
          seeded_nxt = 1'b1;
          state_nxt  = (op_r == MODE_SEED) ? S_IDLE : S_PREP;
        end
      end
      S_RG_PRE: begin
        ram_req.rd_en = 1'b1;
        ram_req.ra    = '0;
        ram_req.rb    = '0;
        state_nxt     = S_RG_LD;
      end
      S_RG_LD: begin
        cur_nxt   = rda;
        cnt_nxt   = '0;
        state_nxt = S_RG_RD;
      end
      S_RG_RD: begin
        ram_req.rd_en = 1'b1;
        ram_req.ra    = nxt_addr;
        ram_req.rb    = far_addr;
        state_nxt     = S_RG_WR;
      end
      S_RG_WR: begin
        // Twist word k from words k, k+1 and k+397
        ram_req.we = 1'b1;
        ram_req.wa = cnt_r;
        ram_req.wd = rdb ^ (ymix >> 1) ^ (ymix[0] ? TWIST_MATRIX : 32'd0);
        cur_nxt    = rda;
        if (cnt_r == LAST_ADDR) begin
          pos_nxt   = '0;
          state_nxt = S_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_RG_RD;
        end
      end
      S_RD: begin
        ram_req.rd_en = 1'b1;
        ram_req.ra    = pos_r;
        ram_req.rb    = pos_r;
        state_nxt     = S_TEMP;
      end
      S_TEMP: begin
        pos_nxt = pos_r + 1'b1;
        if (op_r == MODE_WORD) begin
          res_word_nxt = tw;
          state_nxt    = S_EMIT;
        end else if (ccnt_r + 3'd1 == chunks_r) begin
          if ({1'b0, v_mask} < bound_r) begin
            v_nxt     = v_mask;
            state_nxt = S_EMIT;
          end else begin
            v_nxt     = '0;
            ccnt_nxt  = '0;
            state_nxt = S_PREP;
          end
        end else begin
          v_nxt     = v_shift;
          ccnt_nxt  = ccnt_r + 3'd1;
          state_nxt = S_PREP;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt    = 1'b1;
          out_is_index_nxt = (op_r == MODE_INDEX);
          out_word_nxt     = (op_r == MODE_INDEX) ? 32'd0 : res_word_r;
          out_index_nxt    = (op_r == MODE_INDEX) ? v_r : 52'd0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= WRAP_POS;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    bound_r        <= bound_nxt;
    bits_r         <= bits_nxt;
    chunks_r       <= chunks_nxt;
    ccnt_r         <= ccnt_nxt;
    v_r            <= v_nxt;
    cnt_r          <= cnt_nxt;
    lcg_r          <= lcg_nxt;
    cur_r          <= cur_nxt;
    res_word_r     <= res_word_nxt;
    out_word_r     <= out_word_nxt;
    out_index_r    <= out_index_nxt;
    out_is_index_r <= out_is_index_nxt;
  end

  // Memory writes happen only inside a seeding or regeneration pass
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == S_FILL || state_r == S_RG_WR))
    else $error("state memory written outside a fill or twist step");

  // The last twist step restarts the read position
  a_regen_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RG_WR && cnt_r == LAST_ADDR) |=> (pos_r == '0))
    else $error("position not cleared after regeneration");

  // A word or index draw never reads past the end of the state
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (pos_r < WRAP_POS && seeded_r))
    else $error("word read at wrap position or before seeding");

  // An index result carries a zero word
  a_index_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_index_r) |-> (out_word_r == 32'd0))
    else $error("index result with nonzero word");

endmodule
